[rtl/core/sns_pkg.sv]
// ============================================================================
// sns_pkg - shared types and codes for the SPI NAND operation sequencer
// Command, result, transfer and register codes, word layouts and the
// control/status bundles between the sequencer controller and datapath.
// ============================================================================
package sns_pkg;

  // Word widths on the stream ports
  localparam int IN_TDATA_W  = 104;  // 97 payload bits, padded to bytes
  localparam int OUT_TDATA_W = 160;  // 157 payload bits, padded to bytes
  localparam int CMD_W       = 3;
  localparam int ISSUE_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int PAGE_W  = 14;
  localparam int ROW_W   = 24;
  localparam int COL_W   = 16;
  localparam int RC_W    = 3;
  localparam int LANE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int DIV_CNT_W = 5;  // one quotient bit per step, 32 steps

  // Page size limits and register reset values
  localparam logic [PAGE_W-1:0] PAGE_MIN      = 14'd512;
  localparam logic [PAGE_W-1:0] PAGE_MAX      = 14'd8192;
  localparam logic [PAGE_W-1:0] PAGE_RST      = 14'd2048;
  localparam logic [ADDR_W-1:0] CAPACITY_RST  = 32'd134217728;

  // Host commands (carried in s_tuser)
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BUSDONE = 3'd4;

  // Result codes
  localparam logic [RC_W-1:0] RC_OK      = 3'd0;
  localparam logic [RC_W-1:0] RC_BUSY    = 3'd1;
  localparam logic [RC_W-1:0] RC_RANGE   = 3'd2;
  localparam logic [RC_W-1:0] RC_BUSERR  = 3'd3;
  localparam logic [RC_W-1:0] RC_INVALID = 3'd4;

  // SPI transfers to issue (carried in m_tuser)
  localparam logic [ISSUE_W-1:0] ISS_NONE    = 3'd0;
  localparam logic [ISSUE_W-1:0] ISS_WEN     = 3'd1;
  localparam logic [ISSUE_W-1:0] ISS_PGREAD  = 3'd2;
  localparam logic [ISSUE_W-1:0] ISS_CACHERD = 3'd3;
  localparam logic [ISSUE_W-1:0] ISS_PGLOAD  = 3'd4;
  localparam logic [ISSUE_W-1:0] ISS_PGEXEC  = 3'd5;
  localparam logic [ISSUE_W-1:0] ISS_POLL    = 3'd6;
  localparam logic [ISSUE_W-1:0] ISS_ERASE   = 3'd7;

  // Engine status
  localparam logic [STAT_W-1:0] ST_IDLE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUSY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_IO   = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture input word, seed divider
    logic step;    // one divider iteration
    logic commit;  // apply step, load output register
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;  // current step produces the last quotient bit
  } dp_status_t;

endpackage

[rtl/core/spi_nand_operation_sequencer.sv]
// ============================================================================
// spi_nand_operation_sequencer - non-blocking SPI NAND operation sequencer
// Takes host commands and bus-done events, answers each with the next SPI
// transfer to issue, splitting reads and writes at page boundaries.
// ============================================================================
// Usage:
//   Input words on s_*: command kind in s_tuser, offset/length/host address
//   and bus status in s_tdata. Every input word yields exactly one result
//   word on m_*: transfer to issue in m_tuser, operation end in m_tlast,
//   the remaining result fields in m_tdata.
//   Configuration writes on cfg_* (index 0 page size, 1 capacity, 2 quad
//   mode, 3 quad io) are always ready; write them only while idle.
// Flow:
//   Each word passes through a capture step, a one-bit-per-cycle restoring
//   divider that yields row and column of the working offset, and a commit
//   step. One word is in flight at a time: the next word is accepted only
//   after the previous one has been committed.
// Reset and stall:
//   rst (synchronous) restores register defaults and idles the engine with
//   cursor zero. A finished result holds in the output register while
//   m_tready is low; the next word is still accepted and divided, and its
//   commit waits until the output register frees.
// ============================================================================
module spi_nand_operation_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: flash_offset[31:0], byte_length[63:32], host_address[95:64],
  //          bus_ok[96], zero pad
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sns_pkg::IN_TDATA_W-1:0]      s_tdata,
  // s_tuser: cmd[2:0]
  input  logic [sns_pkg::CMD_W-1:0]           s_tuser,
  // m_tdata: result_code[2:0], page_row[26:3], page_column[42:27],
  //          chunk_bytes_out[56:43], chunk_address[88:57], lane_mode[90:89],
  //          granted_length[122:91], cursor_out[154:123],
  //          engine_status[156:155], zero pad
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sns_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // m_tuser: issue[2:0]
  output logic [sns_pkg::ISSUE_W-1:0]         m_tuser,
  // m_tlast: done_res
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sns_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sns_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sns_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  sns_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTH
  // an accepted word occupies the divider: no back-to-back acceptance
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted during divide");

  // a completed or failed operation never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[156:155] != ST_BUSY)
    else $error("done reported with busy status");

  // any issued transfer comes with a busy result and busy engine
  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ISS_NONE |->
      m_tdata[2:0] == RC_BUSY && m_tdata[156:155] == ST_BUSY)
    else $error("transfer issued without busy result");

  // a bus error result always ends the operation in error
  a_buserr_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == RC_BUSERR |->
      m_tlast && m_tdata[156:155] == ST_ERROR)
    else $error("bus error without error state");
`endif

endmodule

[rtl/core/sns_ctrl.sv]
// ============================================================================
// sns_ctrl - sequencer controller
// Walks each accepted word through capture, serial divide and commit, and
// owns the output valid flag.
// ============================================================================
module sns_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  sns_pkg::dp_status_t status,
  output sns_pkg::dp_ctrl_t   ctrl
);
  import sns_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DIV,
    C_EXEC
  } ctrl_state_t;

  ctrl_state_t state;

  assign s_tready = (state == C_IDLE);

  // Commands to the datapath
  always_comb begin
    ctrl.load   = (state == C_IDLE) && s_tvalid;
    ctrl.step   = (state == C_DIV);
    ctrl.commit = (state == C_EXEC) && (!m_tvalid || m_tready);
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        C_IDLE: if (s_tvalid) state <= C_DIV;
        C_DIV:  if (status.div_done) state <= C_EXEC;
        C_EXEC: if (ctrl.commit) state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
      if (ctrl.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/sns_dp.sv]
// ============================================================================
// sns_dp - sequencer datapath
// Configuration registers, operation state, a restoring divider that yields
// row and column of the working offset, and the registered result word.
// ============================================================================
module sns_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sns_pkg::dp_ctrl_t                     ctrl,
  output sns_pkg::dp_status_t                   status,
  input  logic [sns_pkg::IN_TDATA_W-1:0]        s_tdata,
  input  logic [sns_pkg::CMD_W-1:0]             s_tuser,
  input  logic                                  cfg_valid,
  input  logic [sns_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sns_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic [sns_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic [sns_pkg::ISSUE_W-1:0]           m_tuser,
  output logic                                  m_tlast
);
  import sns_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RD_PAGE,
    PH_RD_POLL,
    PH_RD_CACHE,
    PH_WR_WEN,
    PH_WR_LOAD,
    PH_WR_EXEC,
    PH_WR_POLL,
    PH_ER_WEN,
    PH_ER_ERASE,
    PH_ER_POLL,
    PH_ERROR
  } phase_t;

  // Configuration
  logic [PAGE_W-1:0] page_size;
  logic [ADDR_W-1:0] capacity_bytes;
  logic              quad_mode;
  logic              quad_io;

  // Operation state
  phase_t            phase, phase_next;
  logic [ADDR_W-1:0] cursor, cursor_next;
  logic [ADDR_W-1:0] op_offset, op_offset_next;
  logic [ADDR_W-1:0] bytes_left, bytes_left_next;
  logic [PAGE_W-1:0] chunk_bytes, chunk_bytes_next;
  logic [ADDR_W-1:0] host_pointer, host_pointer_next;

  // Captured input word
  logic [CMD_W-1:0]  in_cmd;
  logic [ADDR_W-1:0] in_off;
  logic [ADDR_W-1:0] in_len;
  logic [ADDR_W-1:0] in_haddr;
  logic              in_ok;

  // Divider
  logic [ADDR_W-1:0]    quot;
  logic [PAGE_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [ADDR_W-1:0]    dividend;
  logic [PAGE_W:0]      trial;
  logic                 trial_ge;

  // Result register
  logic [RC_W-1:0]    o_rc, rc;
  logic [ISSUE_W-1:0] o_issue, issue;
  logic [ROW_W-1:0]   o_row, row_v;
  logic [COL_W-1:0]   o_col, col_v;
  logic [PAGE_W-1:0]  o_cnt, cnt_v;
  logic [ADDR_W-1:0]  o_caddr, caddr_v;
  logic [LANE_W-1:0]  o_lane, lane_v;
  logic               o_done, done_v;
  logic [ADDR_W-1:0]  o_grant, grant_v;
  logic [ADDR_W-1:0]  o_cursor;
  logic [STAT_W-1:0]  o_status, status_v;

  // Helpers
  logic [PAGE_W-1:0] pg;
  logic [PAGE_W-1:0] avail;
  logic [PAGE_W-1:0] chunk_fit;
  logic [ADDR_W-1:0] adv_off;
  logic [ADDR_W-1:0] adv_left;
  logic [ADDR_W-1:0] adv_host;
  logic [ADDR_W-1:0] room;
  logic [ADDR_W-1:0] grant;
  logic              busy;

  // Effective page size, clamped to the legal range
  always_comb begin
    if (page_size < PAGE_MIN) begin
      pg = PAGE_MIN;
    end else if (page_size > PAGE_MAX) begin
      pg = PAGE_MAX;
    end else begin
      pg = page_size;
    end
  end

  assign busy = (phase != PH_IDLE) && (phase != PH_ERROR);

  // Chunk and advance arithmetic
  assign avail     = pg - rem;
  assign chunk_fit = (bytes_left < {{(ADDR_W-PAGE_W){1'b0}}, avail}) ?
                     bytes_left[PAGE_W-1:0] : avail;
  assign adv_off   = op_offset + {{(ADDR_W-PAGE_W){1'b0}}, chunk_bytes};
  assign adv_left  = bytes_left - {{(ADDR_W-PAGE_W){1'b0}}, chunk_bytes};
  assign adv_host  = host_pointer + {{(ADDR_W-PAGE_W){1'b0}}, chunk_bytes};
  assign room      = (cursor < capacity_bytes) ? (capacity_bytes - cursor) : '0;
  assign grant     = (in_len > room) ? room : in_len;

  // Offset whose row and column this word needs
  always_comb begin
    if (s_tuser == CMD_READ) begin
      dividend = cursor;
    end else if (phase == PH_RD_CACHE) begin
      dividend = adv_off;
    end else begin
      dividend = op_offset;
    end
  end

  // Restoring divide step
  assign trial    = {rem, quot[ADDR_W-1]};
  assign trial_ge = (trial >= {1'b0, pg});
  assign status.div_done = (div_cnt == {DIV_CNT_W{1'b1}});

  // Step decode
  always_comb begin
    rc       = RC_INVALID;
    issue    = ISS_NONE;
    row_v    = '0;
    col_v    = '0;
    cnt_v    = '0;
    caddr_v  = '0;
    lane_v   = '0;
    done_v   = 1'b0;
    grant_v  = '0;
    phase_next        = phase;
    cursor_next       = cursor;
    op_offset_next    = op_offset;
    bytes_left_next   = bytes_left;
    chunk_bytes_next  = chunk_bytes;
    host_pointer_next = host_pointer;

    if (in_cmd == CMD_READ || in_cmd == CMD_WRITE || in_cmd == CMD_ERASE) begin
      if (busy) begin
        rc = RC_BUSY;
      end else if (in_cmd == CMD_ERASE) begin
        if (in_off < capacity_bytes) begin
          op_offset_next    = in_off;
          bytes_left_next   = '0;
          chunk_bytes_next  = '0;
          host_pointer_next = '0;
          phase_next        = PH_ER_WEN;
          rc    = RC_BUSY;
          issue = ISS_WEN;
        end else begin
          rc = RC_RANGE;
        end
      end else begin
        grant_v           = grant;
        op_offset_next    = cursor;
        bytes_left_next   = grant;
        chunk_bytes_next  = '0;
        host_pointer_next = in_haddr;
        rc = RC_BUSY;
        if (in_cmd == CMD_READ) begin
          phase_next = PH_RD_PAGE;
          issue      = ISS_PGREAD;
          row_v      = quot[ROW_W-1:0];
        end else begin
          phase_next = PH_WR_WEN;
          issue      = ISS_WEN;
        end
      end
    end else if (in_cmd == CMD_CURSOR) begin
      if (in_off < capacity_bytes) begin
        cursor_next = in_off;
        rc = RC_OK;
      end else begin
        rc = RC_RANGE;
      end
    end else if (in_cmd == CMD_BUSDONE && busy) begin
      if (!in_ok) begin
        // transfer failed: park in error
        phase_next        = PH_ERROR;
        op_offset_next    = '0;
        chunk_bytes_next  = '0;
        host_pointer_next = '0;
        rc     = RC_BUSERR;
        done_v = 1'b1;
      end else begin
        rc = RC_BUSY;
        case (phase)
          PH_RD_PAGE: begin
            phase_next = PH_RD_POLL;
            issue      = ISS_POLL;
          end
          PH_RD_POLL: begin
            chunk_bytes_next = chunk_fit;
            phase_next = PH_RD_CACHE;
            issue      = ISS_CACHERD;
            col_v      = {{(COL_W-PAGE_W){1'b0}}, rem};
            cnt_v      = chunk_fit;
            caddr_v    = host_pointer;
            lane_v     = {quad_io, quad_mode};
          end
          PH_WR_WEN: begin
            chunk_bytes_next = chunk_fit;
            phase_next = PH_WR_LOAD;
            issue      = ISS_PGLOAD;
            col_v      = {{(COL_W-PAGE_W){1'b0}}, rem};
            cnt_v      = chunk_fit;
            caddr_v    = host_pointer;
            lane_v     = {1'b0, quad_mode};
          end
          PH_WR_LOAD: begin
            phase_next = PH_WR_EXEC;
            issue      = ISS_PGEXEC;
            row_v      = quot[ROW_W-1:0];
          end
          PH_WR_EXEC: begin
            phase_next = PH_WR_POLL;
            issue      = ISS_POLL;
          end
          PH_RD_CACHE, PH_WR_POLL: begin
            host_pointer_next = adv_host;
            bytes_left_next   = adv_left;
            op_offset_next    = adv_off;
            if (adv_left != '0) begin
              if (phase == PH_RD_CACHE) begin
                phase_next = PH_RD_PAGE;
                issue      = ISS_PGREAD;
                row_v      = quot[ROW_W-1:0];
              end else begin
                phase_next = PH_WR_WEN;
                issue      = ISS_WEN;
              end
            end else begin
              // last chunk: cursor moves to the end, wraps at capacity
              phase_next  = PH_IDLE;
              cursor_next = (adv_off == capacity_bytes) ? '0 : adv_off;
              rc     = RC_OK;
              done_v = 1'b1;
            end
          end
          PH_ER_WEN: begin
            phase_next = PH_ER_ERASE;
            issue      = ISS_ERASE;
            row_v      = quot[ROW_W-1:0];
          end
          PH_ER_ERASE: begin
            phase_next = PH_ER_POLL;
            issue      = ISS_POLL;
          end
          PH_ER_POLL: begin
            phase_next = PH_IDLE;
            rc     = RC_OK;
            done_v = 1'b1;
          end
          default: rc = RC_INVALID;
        endcase
      end
    end

    case (phase_next)
      PH_IDLE:  status_v = ST_IDLE;
      PH_ERROR: status_v = ST_ERROR;
      default:  status_v = ST_BUSY;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size      <= PAGE_RST;
      capacity_bytes <= CAPACITY_RST;
      quad_mode      <= 1'b0;
      quad_io        <= 1'b0;
      phase          <= PH_IDLE;
      cursor         <= '0;
      op_offset      <= '0;
      bytes_left     <= '0;
      chunk_bytes    <= '0;
      host_pointer   <= '0;
      div_cnt        <= '0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PAGE_SIZE: page_size      <= cfg_data[PAGE_W-1:0];
          CFG_CAPACITY:  capacity_bytes <= cfg_data[ADDR_W-1:0];
          CFG_QUAD_MODE: quad_mode      <= cfg_data[0];
          CFG_QUAD_IO:   quad_io        <= cfg_data[0];
          default: ;
        endcase
      end

      // capture and divider
      if (ctrl.load) begin
        in_cmd   <= s_tuser;
        in_off   <= s_tdata[31:0];
        in_len   <= s_tdata[63:32];
        in_haddr <= s_tdata[95:64];
        in_ok    <= s_tdata[96];
        quot     <= dividend;
        rem      <= '0;
        div_cnt  <= '0;
      end else if (ctrl.step) begin
        rem     <= trial_ge ? (trial[PAGE_W-1:0] - pg) : trial[PAGE_W-1:0];
        quot    <= {quot[ADDR_W-2:0], trial_ge};
        div_cnt <= div_cnt + 1'b1;
      end

      // apply step
      if (ctrl.commit) begin
        phase        <= phase_next;
        cursor       <= cursor_next;
        op_offset    <= op_offset_next;
        bytes_left   <= bytes_left_next;
        chunk_bytes  <= chunk_bytes_next;
        host_pointer <= host_pointer_next;
        o_rc     <= rc;
        o_issue  <= issue;
        o_row    <= row_v;
        o_col    <= col_v;
        o_cnt    <= cnt_v;
        o_caddr  <= caddr_v;
        o_lane   <= lane_v;
        o_done   <= done_v;
        o_grant  <= grant_v;
        o_cursor <= cursor_next;
        o_status <= status_v;
      end
    end
  end

  // Result word
  assign m_tdata = {3'b000, o_status, o_cursor, o_grant, o_lane, o_caddr,
                    o_cnt, o_col, o_row, o_rc};
  assign m_tuser = o_issue;
  assign m_tlast = o_done;

endmodule

[sim/spi_nand_operation_sequencer_tb.sv]
// ============================================================================
// spi_nand_operation_sequencer_tb - self-checking bench for the NAND sequencer
// Drives host commands and bus-done events with bursty traffic, and stalls the
// result side on a pattern of its own. A scoreboard class predicts every
// result word and checks each one field by field, in order.
// ============================================================================
module spi_nand_operation_sequencer_tb;
  import sns_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;   // quiet time after a drain, before register writes
  localparam int LONG_HOLD   = 600;  // result side off long enough to fill up
  localparam int OP_ABORT    = 48;   // events before a long transfer is failed

  // cmd values the block must reject
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

  // s_tdata layout, MSB first
  typedef struct packed {
    logic [6:0]  pad;
    logic        bus_ok;
    logic [31:0] host_addr;
    logic [31:0] length;
    logic [31:0] offset;
  } request_word_t;

  // m_tdata layout, MSB first
  typedef struct packed {
    logic [2:0]  pad;
    logic [1:0]  status;
    logic [31:0] cursor;
    logic [31:0] granted;
    logic [1:0]  lane;
    logic [31:0] chunk_addr;
    logic [13:0] chunk_len;
    logic [15:0] column;
    logic [23:0] row;
    logic [2:0]  rc;
  } result_word_t;

  typedef struct packed {
    logic [2:0]   issue;
    logic         done;
    result_word_t word;
  } transfer_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_RD_PAGE, SQ_RD_POLL, SQ_RD_CACHE, SQ_WR_WEN, SQ_WR_LOAD,
    SQ_WR_EXEC, SQ_WR_POLL, SQ_ER_WEN, SQ_ER_ERASE, SQ_ER_POLL, SQ_ERROR
  } seq_phase_t;

  // --------------------------------------------------------------------------
  // Scoreboard: sequencer state copy plus the queue of expected transfers
  // --------------------------------------------------------------------------
  class sequencer_scoreboard;
    logic [13:0] page_size;
    logic [31:0] capacity;
    logic        quad_mode;
    logic        quad_io;
    seq_phase_t  phase;
    logic [31:0] cursor;
    logic [31:0] op_offset;
    logic [31:0] bytes_left;
    logic [13:0] chunk;
    logic [31:0] host_ptr;
    transfer_t   expected_transfers[$];
    int          errors;

    function new();
      page_size  = PAGE_RST;
      capacity   = CAPACITY_RST;
      quad_mode  = 1'b0;
      quad_io    = 1'b0;
      phase      = SQ_IDLE;
      cursor     = '0;
      op_offset  = '0;
      bytes_left = '0;
      chunk      = '0;
      host_ptr   = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_PAGE_SIZE: page_size = data[13:0];
        CFG_CAPACITY:  capacity  = data;
        CFG_QUAD_MODE: quad_mode = data[0];
        CFG_QUAD_IO:   quad_io   = data[0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != SQ_IDLE && phase != SQ_ERROR;
    endfunction

    function int pending();
      return expected_transfers.size();
    endfunction

    // page size as used, clamped to the legal range
    function logic [31:0] page_bytes();
      if (page_size < PAGE_MIN) return 32'(PAGE_MIN);
      if (page_size > PAGE_MAX) return 32'(PAGE_MAX);
      return 32'(page_size);
    endfunction

    function void next_chunk(logic [31:0] pg);
      logic [31:0] avail;
      avail = pg - op_offset % pg;
      chunk = (avail < bytes_left) ? avail[13:0] : bytes_left[13:0];
    endfunction

    // accepted input word: advance the state and queue the expected transfer
    function void note_request(logic [CMD_W-1:0] cmd, request_word_t req);
      transfer_t   t;
      logic [31:0] pg;
      logic [31:0] room;
      logic [31:0] quot;
      bit          was_busy;
      t = '0;
      t.word.rc = RC_INVALID;
      pg = page_bytes();
      was_busy = busy();
      if (cmd == CMD_READ || cmd == CMD_WRITE || cmd == CMD_ERASE) begin
        if (was_busy) begin
          t.word.rc = RC_BUSY;
        end else if (cmd == CMD_ERASE) begin
          if (req.offset < capacity) begin
            op_offset  = req.offset;
            bytes_left = '0;
            chunk      = '0;
            host_ptr   = '0;
            phase      = SQ_ER_WEN;
            t.word.rc  = RC_BUSY;
            t.issue    = ISS_WEN;
          end else begin
            t.word.rc = RC_RANGE;
          end
        end else begin
          room = (cursor < capacity) ? capacity - cursor : '0;
          t.word.granted = (req.length > room) ? room : req.length;
          op_offset  = cursor;
          bytes_left = t.word.granted;
          chunk      = '0;
          host_ptr   = req.host_addr;
          t.word.rc  = RC_BUSY;
          if (cmd == CMD_READ) begin
            phase = SQ_RD_PAGE;
            t.issue = ISS_PGREAD;
            quot = op_offset / pg;
            t.word.row = quot[23:0];
          end else begin
            phase = SQ_WR_WEN;
            t.issue = ISS_WEN;
          end
        end
      end else if (cmd == CMD_CURSOR) begin
        if (req.offset < capacity) begin
          cursor = req.offset;
          t.word.rc = RC_OK;
        end else begin
          t.word.rc = RC_RANGE;
        end
      end else if (cmd == CMD_BUSDONE && was_busy) begin
        if (!req.bus_ok) begin
          phase     = SQ_ERROR;
          op_offset = '0;
          chunk     = '0;
          host_ptr  = '0;
          t.word.rc = RC_BUSERR;
          t.done    = 1'b1;
        end else begin
          t.word.rc = RC_BUSY;
          case (phase)
            SQ_RD_PAGE: begin
              phase = SQ_RD_POLL;
              t.issue = ISS_POLL;
            end
            SQ_RD_POLL: begin
              next_chunk(pg);
              phase = SQ_RD_CACHE;
              t.issue = ISS_CACHERD;
              t.word.column = 16'(op_offset % pg);
              t.word.chunk_len = chunk;
              t.word.chunk_addr = host_ptr;
              t.word.lane = {quad_io, quad_mode};
            end
            SQ_WR_WEN: begin
              next_chunk(pg);
              phase = SQ_WR_LOAD;
              t.issue = ISS_PGLOAD;
              t.word.column = 16'(op_offset % pg);
              t.word.chunk_len = chunk;
              t.word.chunk_addr = host_ptr;
              t.word.lane = {1'b0, quad_mode};
            end
            SQ_WR_LOAD: begin
              phase = SQ_WR_EXEC;
              t.issue = ISS_PGEXEC;
              quot = op_offset / pg;
              t.word.row = quot[23:0];
            end
            SQ_WR_EXEC: begin
              phase = SQ_WR_POLL;
              t.issue = ISS_POLL;
            end
            SQ_RD_CACHE, SQ_WR_POLL: begin
              host_ptr   = host_ptr + 32'(chunk);
              bytes_left = bytes_left - 32'(chunk);
              op_offset  = op_offset + 32'(chunk);
              if (bytes_left != 0) begin
                if (phase == SQ_RD_CACHE) begin
                  phase = SQ_RD_PAGE;
                  t.issue = ISS_PGREAD;
                  quot = op_offset / pg;
                  t.word.row = quot[23:0];
                end else begin
                  phase = SQ_WR_WEN;
                  t.issue = ISS_WEN;
                end
              end else begin
                // transfer complete: cursor follows, wrapping at capacity
                phase = SQ_IDLE;
                cursor = (op_offset == capacity) ? '0 : op_offset;
                t.word.rc = RC_OK;
                t.done = 1'b1;
              end
            end
            SQ_ER_WEN: begin
              phase = SQ_ER_ERASE;
              t.issue = ISS_ERASE;
              quot = op_offset / pg;
              t.word.row = quot[23:0];
            end
            SQ_ER_ERASE: begin
              phase = SQ_ER_POLL;
              t.issue = ISS_POLL;
            end
            SQ_ER_POLL: begin
              phase = SQ_IDLE;
              t.word.rc = RC_OK;
              t.done = 1'b1;
            end
            default: t.word.rc = RC_INVALID;
          endcase
        end
      end
      t.word.cursor = cursor;
      t.word.status = (phase == SQ_IDLE) ? ST_IDLE : (phase == SQ_ERROR) ? ST_ERROR : ST_BUSY;
      expected_transfers.push_back(t);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
    endfunction

    // accepted result word: compare with the oldest expected transfer
    function void check_transfer(logic [2:0] issue, logic done, result_word_t w);
      transfer_t e;
      if (expected_transfers.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none actual issue %0d data %h",
                 $time, issue, w);
        return;
      end
      e = expected_transfers.pop_front();
      report("result_code", 32'(e.word.rc), 32'(w.rc));
      report("issue", 32'(e.issue), 32'(issue));
      report("page_row", 32'(e.word.row), 32'(w.row));
      report("page_column", 32'(e.word.column), 32'(w.column));
      report("chunk_bytes_out", 32'(e.word.chunk_len), 32'(w.chunk_len));
      report("chunk_address", e.word.chunk_addr, w.chunk_addr);
      report("lane_mode", 32'(e.word.lane), 32'(w.lane));
      report("done_res", 32'(e.done), 32'(done));
      report("granted_length", e.word.granted, w.granted);
      report("cursor_out", e.word.cursor, w.cursor);
      report("engine_status", 32'(e.word.status), 32'(w.status));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [ISSUE_W-1:0]     m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  sequencer_scoreboard sb;
  int burst_left = 0;
  int op_events  = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int rx_left    = 0;
  logic rx_open  = 1'b1;
  int cycle_count = 0;

  spi_nand_operation_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("spi_nand_operation_sequencer: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: check accepted words, stall on its own pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_transfer(m_tuser, m_tlast, m_tdata);
    if (hold_seen != hold_req) begin
      // long hold-off, counted here
      hold_seen = hold_req;
      rx_left = LONG_HOLD;
      rx_open = 1'b0;
    end else if (rx_left > 0) begin
      rx_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          rx_open = 1'b1;
          rx_left = $urandom_range(1, 40);
        end
        4, 5: begin
          rx_open = 1'b1;
          rx_left = $urandom_range(100, 300);
        end
        default: begin
          rx_open = 1'b0;
          rx_left = $urandom_range(1, 60);
        end
      endcase
    end
    m_tready <= rx_open;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // offer one word, wait for it to be taken, then keep bursting or gap
  task automatic send_word(input logic [CMD_W-1:0] cmd, input request_word_t req);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= req;
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, req);
    op_events = sb.busy() ? op_events + 1 : 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drive(input logic [CMD_W-1:0] cmd, input logic [31:0] off,
                       input logic [31:0] len, input logic [31:0] haddr,
                       input logic ok);
    request_word_t req;
    req = '0;
    req.offset = off;
    req.length = len;
    req.host_addr = haddr;
    req.bus_ok = ok;
    send_word(cmd, req);
  endtask

  // finish the running operation with successful bus events
  task automatic run_to_idle();
    while (sb.busy())
      drive(CMD_BUSDONE, $urandom, $urandom, $urandom, 1'b1);
  endtask

  // stop offering and wait until every expected word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic configure(input logic [31:0] page, input logic [31:0] cap,
                           input logic qm, input logic qi);
    logic [CFG_IDX_W-1:0] regs [4];
    logic [31:0]          vals [4];
    regs = '{CFG_PAGE_SIZE, CFG_CAPACITY, CFG_QUAD_MODE, CFG_QUAD_IO};
    vals = '{page, cap, {31'b0, qm}, {31'b0, qi}};
    drain();
    repeat (SETTLE) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // offsets: mostly in range, some near the top, some anywhere
  function automatic logic [31:0] pick_offset();
    logic [31:0] cap;
    cap = sb.capacity;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return (cap == 0) ? $urandom : $urandom % cap;
      5, 6, 7:       return cap - $urandom_range(0, 2 * sb.page_bytes());
      default:       return $urandom;
    endcase
  endfunction

  // lengths: mostly a few pages, sometimes zero, the remaining room or huge
  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 3 * sb.page_bytes());
      6:                return '0;
      7:                return $urandom;
      default:          return (sb.cursor < sb.capacity) ? sb.capacity - sb.cursor
                                                         : $urandom;
    endcase
  endfunction

  // next word: mostly well-formed operations, with noise mixed in
  function automatic void pick_item(output logic [CMD_W-1:0] cmd,
                                    output request_word_t req);
    int r;
    req = '0;
    req.offset = $urandom;
    req.length = $urandom;
    req.host_addr = $urandom;
    req.bus_ok = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (sb.busy()) begin
      if (op_events > OP_ABORT) begin
        cmd = CMD_BUSDONE;
        req.bus_ok = 1'b0;
      end else if (r < 84) begin
        cmd = CMD_BUSDONE;
        req.bus_ok = 1'b1;
      end else if (r < 88) begin
        cmd = CMD_BUSDONE;
        req.bus_ok = 1'b0;
      end else if (r < 94) begin
        cmd = CMD_W'($urandom_range(CMD_READ, CMD_ERASE));
      end else if (r < 97) begin
        cmd = CMD_CURSOR;
        req.offset = pick_offset();
      end else begin
        cmd = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      end
    end else begin
      if (r < 28) begin
        cmd = CMD_READ;
        req.length = pick_length();
      end else if (r < 56) begin
        cmd = CMD_WRITE;
        req.length = pick_length();
      end else if (r < 72) begin
        cmd = CMD_ERASE;
        req.offset = pick_offset();
      end else if (r < 88) begin
        cmd = CMD_CURSOR;
        req.offset = pick_offset();
      end else if (r < 94) begin
        cmd = CMD_BUSDONE;
      end else begin
        cmd = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      end
    end
  endfunction

  task automatic run_random(input int count, input bit hold_rx);
    logic [CMD_W-1:0] cmd;
    request_word_t    req;
    for (int i = 0; i < count; i++) begin
      if (hold_rx && i == count / 3) begin
        // result side goes quiet while words keep coming
        hold_req++;
        burst_left = 12;
      end
      if (i == (2 * count) / 3)
        drain();
      pick_item(cmd, req);
      send_word(cmd, req);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset configuration
    drive(CMD_BUSDONE, '1, '1, '1, 1'b1);             // bus event while idle
    drive(CMD_BAD_LO, '0, '0, '0, 1'b0);
    drive(CMD_BAD_HI, '1, '1, '1, 1'b1);
    drive(CMD_CURSOR, '1, '0, '0, 1'b0);              // cursor out of range
    drive(CMD_ERASE, CAPACITY_RST, '0, '0, 1'b1);     // erase at capacity
    drive(CMD_CURSOR, CAPACITY_RST - 100, '0, '0, 1'b0);
    drive(CMD_READ, '0, '1, '1, 1'b0);                // clamped to the top
    drive(CMD_WRITE, '0, 32'd5, '0, 1'b1);            // start while busy
    drive(CMD_CURSOR, '0, '0, '0, 1'b1);              // cursor move while busy
    run_to_idle();                                    // cursor wraps to zero
    drive(CMD_WRITE, '0, '0, 32'h0000_1234, 1'b0);    // zero-byte write
    run_to_idle();
    drive(CMD_ERASE, CAPACITY_RST - 1, '0, '0, 1'b1);
    run_to_idle();
    drive(CMD_READ, '0, 32'd4396, 32'h8000_0000, 1'b1);
    drive(CMD_BUSDONE, '0, '0, '0, 1'b0);             // bus failure
    drive(CMD_BUSDONE, '0, '0, '0, 1'b1);             // event in error state
    drive(CMD_WRITE, '0, 32'd1, '1, 1'b1);            // start from error
    run_to_idle();

    // random phases over several register settings
    configure(32'd512, 32'hFFFF_FFFF, 1'b1, 1'b0);
    run_random(160, 1'b1);
    configure(32'd8192, 32'd20000, 1'b0, 1'b1);
    run_random(150, 1'b0);
    configure(32'd100, 32'd3000, 1'b1, 1'b1);         // page below minimum
    run_random(130, 1'b0);
    configure(32'h3FFF, 32'd0, 1'b0, 1'b0);           // page above maximum
    run_random(90, 1'b0);
    configure(32'd8192, 32'hFFFF_FFFF, 1'b1, 1'b1);
    run_random(130, 1'b1);
    configure($urandom_range(0, 16383), $urandom, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    run_random(170, 1'b0);
    configure($urandom_range(512, 8192), $urandom_range(1, 200000),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_random(170, 1'b0);

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("spi_nand_operation_sequencer: match");
    else
      $display("spi_nand_operation_sequencer: mismatch");
    $finish;
  end

endmodule

[spi_nand_operation_sequencer.f]
rtl/core/sns_pkg.sv
rtl/core/sns_ctrl.sv
rtl/core/sns_dp.sv
rtl/core/spi_nand_operation_sequencer.sv
sim/spi_nand_operation_sequencer_tb.sv
